// ===== hdl/mono_page_framebuffer_draw_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome page frame buffer
// Shared helpers that wrap concurrent assertions on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MPFB_ASSERT_IMPLY(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("frame buffer check failed");
`define MPFB_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("frame buffer sequence check failed");
`else
`define MPFB_ASSERT_IMPLY(label, cond, expr)
`define MPFB_ASSERT_NEXT(label, cond, expr)
`endif

`endif

// ===== hdl/mpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Monochrome page frame buffer package
// Screen geometry, store layout, command and register codes.
// ----------------------------------------------------------------------------
package mpfb_pkg;

	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_SIZE     = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int ADDR_W         = $clog2(STORE_SIZE);

	localparam int CMD_W      = 3;
	localparam int S_DATA_W   = 56;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CMD_W-1:0] CMD_PIXEL  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FILL   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RECT   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd4;
	localparam logic [CMD_W-1:0] CMD_GLYPH  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_W = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_H = 2'd2;

	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] BYTE_ZEROS = 8'h00;

	// Store address of a column within a page.
	function automatic logic [ADDR_W-1:0] store_addr(input logic [8:0] col,
		input logic [8:0] page);
		logic [ADDR_W+9:0] full;
		full = (ADDR_W+10)'(col) + (ADDR_W+10)'(page) * (ADDR_W+10)'(DISPLAY_WIDTH);
		return full[ADDR_W-1:0];
	endfunction

endpackage

// ===== hdl/mpfb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/mono_page_framebuffer_draw.sv =====
// A result not yet taken holds the engine in S_DONE. One command at a time through the one
// store port pair. Pixels and rectangles read-modify-write the byte of each on-screen pixel
// and skip clipped pixels; fill and clear write every store byte. After reset a clearing pass
// writes all STORE_SIZE (1024) store bytes before the first command transfer; configuration
// is always taken.
// ----------------------------------------------------------------------------
// Monochrome page frame buffer drawing engine
// Executes pixel, fill, clear, rectangle, cursor, glyph and read commands on a page store.
// ----------------------------------------------------------------------------
`include "mono_page_framebuffer_draw_defines.svh"

module mono_page_framebuffer_draw (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// x_pos, y_pos, rect_width, rect_height, color, glyph_row, row_index, zero pad
	input  logic [mpfb_pkg::S_DATA_W-1:0]    s_tdata,
	// cmd
	input  logic [mpfb_pkg::CMD_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_data
	output logic [7:0]                       m_tdata,
	// status
	output logic                             m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mpfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import mpfb_pkg::*;

	localparam logic [2:0] S_FILL = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_STEP = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]        state_q;
	logic              init_q;
	logic              inv_q;
	logic [4:0]        fw_q;
	logic [5:0]        fh_q;
	logic [7:0]        cx_q, cy_q;
	logic [7:0]        bx_q, by_q, w_q, h_q, i_q, j_q;
	logic              col_q, glyph_q, rdcmd_q, any_q, chk_q, stat_q, pcol_q;
	logic [15:0]       gsh_q;
	logic [7:0]        fill_q, rdd_q;
	logic [ADDR_W-1:0] fcnt_q, addr_q;
	logic [2:0]        bit_q;
	logic              m_valid_q, m_user_q;
	logic [7:0]        m_data_q;

	logic [7:0]  x_in, y_in, w_in, h_in;
	logic        c_in;
	logic [15:0] g_in;
	logic [4:0]  r_in;
	logic        accept;
	logic [8:0]  px, py;
	logic        pix_in, pix_color;
	logic        last_i, last_j, adv_done;
	logic [7:0]  next_i, next_j;
	logic        ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]  ram_wdata, ram_rdata, mask, modified;
	logic        glyph_skip;

	assign x_in = s_tdata[7:0];
	assign y_in = s_tdata[15:8];
	assign w_in = s_tdata[23:16];
	assign h_in = s_tdata[31:24];
	assign c_in = s_tdata[32];
	assign g_in = s_tdata[48:33];
	assign r_in = s_tdata[53:49];

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_user_q;

	assign glyph_skip = ({1'b0, cx_q} + {4'b0, fw_q} >= 9'(DISPLAY_WIDTH)) ||
		({1'b0, cy_q} + {3'b0, fh_q} >= 9'(DISPLAY_HEIGHT)) ||
		({1'b0, r_in} >= fh_q);

	assign px        = {1'b0, bx_q} + {1'b0, i_q};
	assign py        = {1'b0, by_q} + {1'b0, j_q};
	assign pix_in    = (px < 9'(DISPLAY_WIDTH)) && (py < 9'(DISPLAY_HEIGHT));
	assign pix_color = (glyph_q ? (gsh_q[15] ? col_q : ~col_q) : col_q) ^ inv_q;

	assign last_i   = ({1'b0, i_q} + 9'd1) == {1'b0, w_q};
	assign last_j   = ({1'b0, j_q} + 9'd1) == {1'b0, h_q};
	assign adv_done = last_i && last_j;
	assign next_i   = last_i ? 8'd0 : i_q + 8'd1;
	assign next_j   = last_i ? j_q + 8'd1 : j_q;

	assign mask     = 8'd1 << bit_q;
	assign modified = pcol_q ? (ram_rdata | mask) : (ram_rdata & ~mask);

	assign ram_re    = (state_q == S_RD);
	assign ram_we    = (state_q == S_FILL) || ((state_q == S_WR) && !rdcmd_q);
	assign ram_waddr = (state_q == S_FILL) ? fcnt_q : addr_q;
	assign ram_wdata = (state_q == S_FILL) ? fill_q : modified;

	mpfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_SIZE)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(addr_q),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b1;
			fw_q  <= 5'd7;
			fh_q  <= 6'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_INVERT: inv_q <= cfg_data[0];
				CFG_FONT_W: fw_q  <= cfg_data[4:0];
				CFG_FONT_H: fh_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_FILL;
			init_q    <= 1'b1;
			fill_q    <= BYTE_ZEROS;
			fcnt_q    <= '0;
			cx_q      <= 8'd0;
			cy_q      <= 8'd0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_FILL: begin
					fcnt_q <= fcnt_q + 1'b1;
					if (fcnt_q == ADDR_W'(STORE_SIZE - 1)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_DONE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rdd_q   <= 8'd0;
						stat_q  <= 1'b0;
						chk_q   <= 1'b0;
						any_q   <= 1'b0;
						rdcmd_q <= 1'b0;
						glyph_q <= 1'b0;
						col_q   <= c_in;
						i_q     <= 8'd0;
						j_q     <= 8'd0;
						fcnt_q  <= '0;
						unique case (s_tuser) inside
							CMD_PIXEL, CMD_RECT: begin
								bx_q  <= x_in;
								by_q  <= y_in;
								chk_q <= 1'b1;
								if (s_tuser == CMD_PIXEL) begin
									w_q     <= 8'd1;
									h_q     <= 8'd1;
									state_q <= S_STEP;
								end else begin
									w_q     <= w_in;
									h_q     <= h_in;
									state_q <= (w_in == 8'd0 || h_in == 8'd0) ? S_DONE : S_STEP;
								end
							end
							CMD_FILL: begin
								fill_q  <= c_in ? BYTE_ONES : BYTE_ZEROS;
								state_q <= S_FILL;
							end
							CMD_CLEAR: begin
								fill_q  <= BYTE_ZEROS;
								cx_q    <= 8'd0;
								cy_q    <= 8'd0;
								state_q <= S_FILL;
							end
							CMD_CURSOR: begin
								cx_q    <= x_in;
								cy_q    <= y_in;
								state_q <= S_DONE;
							end
							CMD_GLYPH: begin
								glyph_q <= 1'b1;
								gsh_q   <= g_in;
								bx_q    <= cx_q;
								by_q    <= cy_q + {3'b0, r_in};
								w_q     <= {3'b0, fw_q};
								h_q     <= 8'd1;
								if (glyph_skip) begin
									stat_q  <= 1'b1;
									state_q <= S_DONE;
								end else begin
									if ({1'b0, r_in} + 6'd1 == fh_q) begin
										cx_q <= cx_q + {3'b0, fw_q};
									end
									state_q <= (fw_q == 5'd0) ? S_DONE : S_STEP;
								end
							end
							CMD_READ: begin
								if ({1'b0, x_in} < 9'(DISPLAY_WIDTH) &&
									{1'b0, y_in} < 9'(PAGE_COUNT)) begin
									addr_q  <= store_addr({1'b0, x_in}, {1'b0, y_in});
									rdcmd_q <= 1'b1;
									state_q <= S_RD;
								end else begin
									stat_q  <= 1'b1;
									state_q <= S_DONE;
								end
							end
							default: begin
								stat_q  <= 1'b1;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_STEP: begin
					if (pix_in) begin
						addr_q  <= store_addr(px, {3'b0, py[8:3]});
						bit_q   <= py[2:0];
						pcol_q  <= pix_color;
						any_q   <= 1'b1;
						state_q <= S_RD;
					end else begin
						i_q     <= next_i;
						j_q     <= next_j;
						gsh_q   <= gsh_q << 1;
						state_q <= adv_done ? S_DONE : S_STEP;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (rdcmd_q) begin
						rdd_q   <= ram_rdata;
						state_q <= S_DONE;
					end else begin
						i_q     <= next_i;
						j_q     <= next_j;
						gsh_q   <= gsh_q << 1;
						state_q <= adv_done ? S_DONE : S_STEP;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= rdd_q;
						m_user_q  <= stat_q | (chk_q & ~any_q);
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MPFB_ASSERT_IMPLY(a_store_write_phase, ram_we, state_q == S_FILL || state_q == S_WR)
	`MPFB_ASSERT_IMPLY(a_no_cmd_during_init, init_q, !s_tready)
	`MPFB_ASSERT_IMPLY(a_step_in_bounds, state_q == S_STEP, i_q < w_q && j_q < h_q)
	`MPFB_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE)

endmodule

// ===== dv/mono_page_framebuffer_draw_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the monochrome page frame buffer drawing engine
// Sends drawing commands over the stream input, keeps its own copy of the
// frame store, cursor and font registers, and checks every status and read
// byte that comes back, first for a directed set and then for random traffic
// under several register settings and idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpfb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 400000;
	localparam int ITEMS_PER_SEGMENT = 130;
	localparam int SEGMENTS = 6;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [7:0]       x_pos;
		logic [7:0]       y_pos;
		logic [7:0]       rect_width;
		logic [7:0]       rect_height;
		logic             color;
		logic [15:0]      glyph_row;
		logic [4:0]       row_index;
	} draw_cmd_t;

	typedef struct {
		logic [7:0] read_data;
		logic       status;
	} draw_reply_t;

	class draw_scoreboard;
		logic [7:0]  frame [STORE_SIZE];
		logic [7:0]  cursor_col;
		logic [7:0]  cursor_row;
		logic        invert;
		logic [4:0]  font_w;
		logic [5:0]  font_h;
		draw_reply_t want_replies[$];
		int          errors;

		function new();
			fill_frame(BYTE_ZEROS);
			cursor_col = '0;
			cursor_row = '0;
			invert = 1'b1;
			font_w = 5'd7;
			font_h = 6'd10;
			errors = 0;
		endfunction

		function void fill_frame(logic [7:0] value);
			foreach (frame[k])
				frame[k] = value;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				CFG_INVERT: invert = value[0];
				CFG_FONT_W: font_w = value[4:0];
				CFG_FONT_H: font_h = value[5:0];
				default: ;
			endcase
		endfunction

		function bit plot(int col, int row, logic color);
			int idx;
			if (col >= DISPLAY_WIDTH || row >= DISPLAY_HEIGHT)
				return 1'b0;
			idx = col + (row / 8) * DISPLAY_WIDTH;
			frame[idx][row % 8] = color ^ invert;
			return 1'b1;
		endfunction

		function void apply_command(draw_cmd_t c);
			draw_reply_t r;
			bit          any;
			logic        bit_on;
			int          i;
			int          j;
			r.read_data = BYTE_ZEROS;
			r.status = 1'b0;
			case (c.cmd)
				CMD_PIXEL: r.status = !plot(c.x_pos, c.y_pos, c.color);
				CMD_FILL: fill_frame(c.color ? BYTE_ONES : BYTE_ZEROS);
				CMD_CLEAR: begin
					fill_frame(BYTE_ZEROS);
					cursor_col = '0;
					cursor_row = '0;
				end
				CMD_RECT: begin
					any = 1'b0;
					for (j = 0; j < c.rect_height; j++)
						for (i = 0; i < c.rect_width; i++)
							if (plot(int'(c.x_pos) + i, int'(c.y_pos) + j, c.color))
								any = 1'b1;
					r.status = !any;
				end
				CMD_CURSOR: begin
					cursor_col = c.x_pos;
					cursor_row = c.y_pos;
				end
				CMD_GLYPH: begin
					if (int'(cursor_col) + int'(font_w) >= DISPLAY_WIDTH ||
						int'(cursor_row) + int'(font_h) >= DISPLAY_HEIGHT) begin
						r.status = 1'b1;
					end else if (c.row_index >= font_h) begin
						r.status = 1'b1;
					end else begin
						for (j = 0; j < font_w; j++) begin
							bit_on = 1'b0;
							if (j < 16)
								bit_on = c.glyph_row[15-j];
							void'(plot(int'(cursor_col) + j, int'(cursor_row) + int'(c.row_index),
								bit_on ? c.color : ~c.color));
						end
						if (int'(c.row_index) + 1 == int'(font_h))
							cursor_col = cursor_col + 8'(font_w);
					end
				end
				CMD_READ: begin
					if (c.x_pos < DISPLAY_WIDTH && c.y_pos < PAGE_COUNT)
						r.read_data = frame[int'(c.x_pos) + int'(c.y_pos) * DISPLAY_WIDTH];
					else
						r.status = 1'b1;
				end
				default: r.status = 1'b1;
			endcase
			want_replies.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_reply(logic [7:0] rd, logic st);
			draw_reply_t w;
			if (want_replies.size() == 0) begin
				report($sformatf("result with nothing expected, data=%02h status=%0b", rd, st));
				return;
			end
			w = want_replies.pop_front();
			if (rd !== w.read_data)
				report($sformatf("read data %02h, expected %02h", rd, w.read_data));
			if (st !== w.status)
				report($sformatf("status %0b, expected %0b", st, w.status));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// x_pos, y_pos, rect_width, rect_height, color, glyph_row, row_index, zero pad
	logic [S_DATA_W-1:0]   s_tdata;
	// cmd
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// read_data
	logic [7:0]            m_tdata;
	// status
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	draw_scoreboard sb;
	int send_idle_pct = 35;
	int recv_idle_pct = 55;
	int sent = 0;
	int stall_cycles = 0;

	mono_page_framebuffer_draw dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (m_tvalid && m_tready)
				sb.check_reply(m_tdata, m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic draw_cmd_t mk(logic [CMD_W-1:0] cmd, logic [7:0] x, logic [7:0] y,
		logic [7:0] w, logic [7:0] h, logic color, logic [15:0] glyph, logic [4:0] row);
		draw_cmd_t c;
		c.cmd = cmd;
		c.x_pos = x;
		c.y_pos = y;
		c.rect_width = w;
		c.rect_height = h;
		c.color = color;
		c.glyph_row = glyph;
		c.row_index = row;
		return c;
	endfunction

	function automatic draw_cmd_t random_fields();
		return mk(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom), 16'($urandom), 5'($urandom));
	endfunction

	function automatic draw_cmd_t random_item();
		draw_cmd_t c;
		int        sel;
		c = random_fields();
		sel = $urandom_range(99);
		if (sel < 18) begin
			c.cmd = CMD_PIXEL;
			if ($urandom_range(3) != 0) begin
				c.x_pos = 8'($urandom_range(135));
				c.y_pos = 8'($urandom_range(70));
			end
		end else if (sel < 20) begin
			c.cmd = CMD_FILL;
		end else if (sel < 21) begin
			c.cmd = CMD_CLEAR;
		end else if (sel < 38) begin
			c.cmd = CMD_RECT;
			if ($urandom_range(3) != 0) begin
				c.x_pos = 8'($urandom_range(135));
				c.y_pos = 8'($urandom_range(70));
			end
			case ($urandom_range(9))
				0: c.rect_height = 8'($urandom_range(6));
				1: c.rect_width = 8'($urandom_range(6));
				default: begin
					c.rect_width = 8'($urandom_range(20));
					c.rect_height = 8'($urandom_range(12));
				end
			endcase
		end else if (sel < 43) begin
			c.cmd = CMD_CURSOR;
		end else if (sel < 50) begin
			c.cmd = CMD_GLYPH;
		end else if (sel < 52) begin
			c.cmd = CMD_UNUSED;
		end else begin
			c.cmd = CMD_READ;
			if ($urandom_range(7) != 0) begin
				c.x_pos = 8'($urandom_range(DISPLAY_WIDTH - 1));
				c.y_pos = 8'($urandom_range(PAGE_COUNT - 1));
			end
		end
		return c;
	endfunction

	task automatic send(draw_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.cmd;
		s_tdata <= {2'b00, c.row_index, c.glyph_row, c.color, c.rect_height, c.rect_width,
			c.y_pos, c.x_pos};
		do @(posedge clk); while (!s_tready);
		sb.apply_command(c);
		sent++;
		@(negedge clk);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.want_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(logic inv, logic [4:0] fw, logic [5:0] fh);
		logic [CFG_IDX_W-1:0]  regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs = '{CFG_INVERT, CFG_FONT_W, CFG_FONT_H};
		vals = '{{5'b0, inv}, {1'b0, fw}, fh};
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(regs[k], vals[k]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// A well-formed character: place the cursor where the box fits, send every
	// row in order (now and then a stray row index), then read back its pages.
	task automatic draw_character();
		draw_cmd_t c;
		int        cx;
		int        cy;
		int        n_chars;
		int        r;
		cx = $urandom_range(DISPLAY_WIDTH - 1 - int'(sb.font_w));
		cy = $urandom_range(DISPLAY_HEIGHT - 1 - int'(sb.font_h));
		c = random_fields();
		c.cmd = CMD_CURSOR;
		c.x_pos = 8'(cx);
		c.y_pos = 8'(cy);
		send(c);
		n_chars = $urandom_range(3, 1);
		repeat (n_chars) begin
			for (r = 0; r < sb.font_h; r++) begin
				c = random_fields();
				c.cmd = CMD_GLYPH;
				c.row_index = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'(r);
				send(c);
			end
		end
		repeat (4) begin
			c = random_fields();
			c.cmd = CMD_READ;
			c.x_pos = 8'(cx + $urandom_range(int'(sb.font_w) * n_chars));
			c.y_pos = 8'($urandom_range((cy + int'(sb.font_h) - 1) / 8, cy / 8));
			send(c);
		end
	endtask

	initial begin
		logic       seg_inv [SEGMENTS];
		logic [4:0] seg_fw  [SEGMENTS];
		logic [5:0] seg_fh  [SEGMENTS];
		int         seg_end;
		int         k;

		seg_inv = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		seg_fw = '{5'd1, 5'd16, 5'd5, 5'd8, 5'd16, 5'd1};
		seg_fh = '{6'd1, 6'd32, 6'd8, 6'd16, 6'd1, 6'd32};
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		send(mk(CMD_READ, 0, 0, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_PIXEL, 0, 0, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_PIXEL, 127, 63, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_PIXEL, 128, 0, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_PIXEL, 255, 255, 0, 0, 1, 16'h0000, 0));
		send(mk(CMD_READ, 0, 0, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_READ, 127, 7, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_READ, 128, 0, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_READ, 0, 8, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_RECT, 120, 60, 20, 10, 0, 16'h0000, 0));
		send(mk(CMD_RECT, 0, 0, 0, 5, 0, 16'h0000, 0));
		send(mk(CMD_RECT, 200, 250, 10, 10, 0, 16'h0000, 0));
		send(mk(CMD_READ, 124, 7, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_CURSOR, 0, 0, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_GLYPH, 0, 0, 0, 0, 1, 16'hFFFF, 0));
		send(mk(CMD_GLYPH, 0, 0, 0, 0, 0, 16'hA5A5, 9));
		send(mk(CMD_GLYPH, 0, 0, 0, 0, 1, 16'h8001, 10));
		send(mk(CMD_READ, 3, 1, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_CURSOR, 121, 0, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_GLYPH, 0, 0, 0, 0, 1, 16'hFFFF, 0));
		send(mk(CMD_CURSOR, 0, 54, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_GLYPH, 0, 0, 0, 0, 1, 16'hFFFF, 0));
		send(mk(CMD_UNUSED, 0, 0, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_FILL, 0, 0, 0, 0, 1, 16'h0000, 0));
		send(mk(CMD_RECT, 0, 0, 255, 255, 1, 16'h0000, 0));
		send(mk(CMD_READ, 64, 3, 0, 0, 0, 16'h0000, 0));
		send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 16'h0000, 0));

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 2) begin
				send_idle_pct = 55;
				recv_idle_pct = 35;
			end else if (seg == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pause_until_drained();
			configure(seg_inv[seg], seg_fw[seg], seg_fh[seg]);
			seg_end = sent + ITEMS_PER_SEGMENT;
			while (sent < seg_end) begin
				k = $urandom_range(99);
				if (k < 12)
					draw_character();
				else if (k == 12)
					pause_until_drained();
				else
					send(random_item());
			end
		end

		pause_until_drained();
		repeat (20) @(negedge clk);
		if (sb.want_replies.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.want_replies.size()));
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mpfb_pkg.sv
hdl/mpfb_ram.sv
hdl/mono_page_framebuffer_draw.sv
dv/mono_page_framebuffer_draw_tb.sv
